/* rtl/ptt_pkg.sv */
`timescale 1ns / 1ps
package ptt_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int ID_BITS_DEF       = 32;
	localparam int TIMER_BITS_DEF    = 16;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_RELEASE  = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;

	localparam logic [2:0] ST_ACCEPTED  = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_RELEASED  = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_TIMED_OUT = 3'd4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] request_id;
		logic [15:0] timeout_ticks;
		logic [31:0] response_data;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] result_id;
		logic [31:0] result_data;
		logic        last;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tick_expiry;
		logic scan_last;
	} sts_t;

endpackage

/* rtl/ptt_ctrl.sv */
`timescale 1ns / 1ps
module ptt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ptt_pkg::sts_t sts,
	output ptt_pkg::cmd_t cmd,
	output logic          busy
);

	ptt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		busy        = 1'b1;
		case (state_q)
			ptt_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ptt_pkg::S_EXEC;
				end
			end
			ptt_pkg::S_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = sts.tick_expiry ? ptt_pkg::S_SCAN : ptt_pkg::S_IDLE;
			end
			ptt_pkg::S_SCAN: begin
				cmd.emit = 1'b1;
				if (sts.scan_last) begin
					state_d = ptt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptt_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/ptt_dp.sv */
`timescale 1ns / 1ps
module ptt_dp #(
	parameter int TABLE_ENTRIES = ptt_pkg::TABLE_ENTRIES_DEF,
	parameter int ID_BITS       = ptt_pkg::ID_BITS_DEF,
	parameter int TIMER_BITS    = ptt_pkg::TIMER_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ptt_pkg::req_t req,
	input  ptt_pkg::cmd_t cmd,
	output ptt_pkg::sts_t sts,
	output ptt_pkg::rsp_t result,
	output logic          result_valid
);

	localparam int IXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

	ptt_pkg::req_t          in_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] pend_q;
	logic [ID_BITS-1:0]     id_q  [TABLE_ENTRIES];
	logic [TIMER_BITS-1:0]  cnt_q [TABLE_ENTRIES];
	ptt_pkg::rsp_t          out_q;
	logic                   out_valid_q;

	logic [ID_BITS-1:0]       id_in;
	logic [31:0]              tmo_w;
	logic [TIMER_BITS-1:0]    cnt_new;
	logic                     free_any, match_any;
	logic [IXW-1:0]           free_idx, match_idx, scan_idx;
	logic [TABLE_ENTRIES-1:0] exp_mask;
	logic                     pend_single;

	assign id_in = ID_BITS'(in_q.request_id);

	always_comb begin
		tmo_w = (in_q.timeout_ticks == '0) ? 32'd1 : 32'(in_q.timeout_ticks);
		if (tmo_w > TMAX) begin
			tmo_w = TMAX;
		end
		cnt_new = TIMER_BITS'(tmo_w);
	end

	// lowest free slot, lowest matching slot, lowest pending expiry
	always_comb begin
		free_any  = 1'b0;
		match_any = 1'b0;
		free_idx  = '0;
		match_idx = '0;
		scan_idx  = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IXW'(i);
			end
			if (valid_q[i] && (id_q[i] == id_in)) begin
				match_any = 1'b1;
				match_idx = IXW'(i);
			end
			if (pend_q[i]) begin
				scan_idx = IXW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			exp_mask[i] = valid_q[i] && (cnt_q[i] <= TIMER_BITS'(1));
		end
	end

	assign pend_single     = ((pend_q & (pend_q - TABLE_ENTRIES'(1))) == '0);
	assign sts.tick_expiry = (in_q.opcode == ptt_pkg::OP_TICK) && (|exp_mask);
	assign sts.scan_last   = pend_single;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.emit || (cmd.execute &&
				(in_q.opcode inside {ptt_pkg::OP_REGISTER, ptt_pkg::OP_RELEASE}));
			if (cmd.execute) begin
				case (in_q.opcode)
					ptt_pkg::OP_REGISTER: begin
						if (free_any) begin
							valid_q[free_idx] <= 1'b1;
						end
					end
					ptt_pkg::OP_RELEASE: begin
						if (match_any) begin
							valid_q[match_idx] <= 1'b0;
						end
					end
					ptt_pkg::OP_TICK: begin
						valid_q <= valid_q & ~exp_mask;
						pend_q  <= exp_mask;
					end
					default: begin
					end
				endcase
			end
			if (cmd.emit) begin
				pend_q[scan_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= req;
		end
		if (cmd.execute) begin
			case (in_q.opcode)
				ptt_pkg::OP_REGISTER: begin
					out_q.result_id   <= 32'(id_in);
					out_q.result_data <= '0;
					out_q.last        <= 1'b1;
					if (free_any) begin
						id_q[free_idx]  <= id_in;
						cnt_q[free_idx] <= cnt_new;
						out_q.status    <= ptt_pkg::ST_ACCEPTED;
					end else begin
						out_q.status <= ptt_pkg::ST_FULL;
					end
				end
				ptt_pkg::OP_RELEASE: begin
					out_q.result_id <= 32'(id_in);
					out_q.last      <= 1'b1;
					if (match_any) begin
						out_q.status      <= ptt_pkg::ST_RELEASED;
						out_q.result_data <= in_q.response_data;
					end else begin
						out_q.status      <= ptt_pkg::ST_NOT_FOUND;
						out_q.result_data <= '0;
					end
				end
				ptt_pkg::OP_TICK: begin
					for (int i = 0; i < TABLE_ENTRIES; i++) begin
						if (valid_q[i] && (cnt_q[i] != '0)) begin
							cnt_q[i] <= cnt_q[i] - TIMER_BITS'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.emit) begin
			out_q.status      <= ptt_pkg::ST_TIMED_OUT;
			out_q.result_id   <= 32'(id_q[scan_idx]);
			out_q.result_data <= '0;
			out_q.last        <= pend_single;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule

/* rtl/pending_request_timeout_table.sv */
`timescale 1ns / 1ps
// Register and release: the word is captured and executed against the table, then its result
// word strobes; busy only during execution, so the next word can be taken as that result strobes.
// Tick: with k expired slots, k result words follow on consecutive cycles in the expiry scan;
// busy through execution and the scan, so no new word is taken until the last expiry word strobes.
// Expiries leave one per cycle through the single result register in the expiry scan.
// arst_n empties the table at once (valid and pending bits only); results cannot be stalled.
module pending_request_timeout_table #(
	parameter int TABLE_ENTRIES = ptt_pkg::TABLE_ENTRIES_DEF,
	parameter int ID_BITS       = ptt_pkg::ID_BITS_DEF,
	parameter int TIMER_BITS    = ptt_pkg::TIMER_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ptt_pkg::req_t req,
	output ptt_pkg::rsp_t result,
	output logic          result_valid
);

	ptt_pkg::cmd_t cmd;
	ptt_pkg::sts_t sts;

	// Sequencer: capture the word, execute it against the table, then drain any expiries a tick finds.
	ptt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Table of slots with parallel id compare, free-slot search and countdowns.
	ptt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ID_BITS       (ID_BITS),
		.TIMER_BITS    (TIMER_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

	// An accepted word always makes the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// Every result word is produced by work done while busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result word without preceding work");

	// Expiry words come back to back until the one flagged last.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |=> result_valid)
		else $error("gap in expiry burst");

	// Only expiry bursts carry words that are not last.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status != ptt_pkg::ST_TIMED_OUT)) |-> result.last)
		else $error("single result word not flagged last");

endmodule

/* tb/tb_pending_request_timeout_table.sv */
`timescale 1ns / 1ps
module tb_pending_request_timeout_table;

	localparam int          SLOTS     = ptt_pkg::TABLE_ENTRIES_DEF;
	localparam logic [1:0]  OP_NONE   = 2'd3;  // opcode with no meaning, block ignores it
	localparam int          PHASE_LEN = 136;
	localparam int          DRAIN_MAX = 2000;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	ptt_pkg::req_t req;
	ptt_pkg::rsp_t result;
	logic          result_valid;

	// shadow copy of the table
	logic        slot_live  [SLOTS];
	logic [31:0] slot_id    [SLOTS];
	logic [15:0] slot_count [SLOTS];

	ptt_pkg::rsp_t awaited_results[$];
	ptt_pkg::rsp_t oldest;
	int            mismatches;

	// one row of the directed plan; reps repeats the word with the id stepping up by one
	typedef struct {
		ptt_pkg::req_t w;
		int unsigned   reps;
		bit            typed;
		ptt_pkg::rsp_t lit;
	} plan_row_t;

	plan_row_t plan[$];

	pending_request_timeout_table DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result       (result),
		.result_valid (result_valid)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop on a hung run
	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// append a predicted result word
	task automatic queue_result(input ptt_pkg::rsp_t r);
		awaited_results = {awaited_results, r};
	endtask

	// append a row to the directed plan
	task automatic add_row(input plan_row_t p);
		plan = {plan, p};
	endtask

	function automatic ptt_pkg::rsp_t make_rsp(input logic [2:0] st, input logic [31:0] id,
			input logic [31:0] data, input logic last);
		ptt_pkg::rsp_t r;
		r.status      = st;
		r.result_id   = id;
		r.result_data = data;
		r.last        = last;
		return r;
	endfunction

	function automatic plan_row_t row(input logic [1:0] op, input logic [31:0] id,
			input logic [15:0] tmo, input logic [31:0] data, input int unsigned reps,
			input bit typed, input logic [2:0] st, input logic [31:0] rid,
			input logic [31:0] rdata);
		plan_row_t p;
		p.w.opcode        = op;
		p.w.request_id    = id;
		p.w.timeout_ticks = tmo;
		p.w.response_data = data;
		p.reps            = reps;
		p.typed           = typed;
		p.lit             = make_rsp(st, rid, rdata, 1'b1);
		return p;
	endfunction

	// Advance the shadow table by one accepted word; queue what it should produce
	// unless keep is low (the caller supplies a typed-in result instead).
	task automatic apply_to_table(input ptt_pkg::req_t w, input bit keep);
		logic [15:0] tmo;
		int          hit;
		int          n_expire;
		int          k;
		hit      = -1;
		n_expire = 0;
		k        = 0;
		case (w.opcode)
			ptt_pkg::OP_REGISTER: begin
				tmo = (w.timeout_ticks == 16'd0) ? 16'd1 : w.timeout_ticks;
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && !slot_live[i])
						hit = i;
				if (hit >= 0) begin
					slot_live[hit]  = 1'b1;
					slot_id[hit]    = w.request_id;
					slot_count[hit] = tmo;
					if (keep)
						queue_result(make_rsp(ptt_pkg::ST_ACCEPTED, w.request_id, '0,
							1'b1));
				end else if (keep) begin
					queue_result(make_rsp(ptt_pkg::ST_FULL, w.request_id, '0, 1'b1));
				end
			end
			ptt_pkg::OP_RELEASE: begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && slot_live[i] && slot_id[i] == w.request_id)
						hit = i;
				if (hit >= 0) begin
					slot_live[hit] = 1'b0;
					if (keep)
						queue_result(make_rsp(ptt_pkg::ST_RELEASED, w.request_id,
							w.response_data, 1'b1));
				end else if (keep) begin
					queue_result(make_rsp(ptt_pkg::ST_NOT_FOUND, w.request_id, '0,
						1'b1));
				end
			end
			ptt_pkg::OP_TICK: begin
				// count expiries first so the final one can carry last
				for (int i = 0; i < SLOTS; i++)
					if (slot_live[i] && slot_count[i] <= 16'd1)
						n_expire++;
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_live[i]) begin
						if (slot_count[i] != 16'd0)
							slot_count[i] = slot_count[i] - 16'd1;
						if (slot_count[i] == 16'd0) begin
							slot_live[i] = 1'b0;
							k++;
							if (keep)
								queue_result(make_rsp(ptt_pkg::ST_TIMED_OUT, slot_id[i],
									'0, k == n_expire));
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// Hold start and the word until the block takes it, then update the prediction.
	task automatic send_word(input ptt_pkg::req_t w, input bit keep);
		start <= 1'b1;
		req   <= w;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_to_table(w, keep);
	endtask

	// Drop start and wait out every outstanding result word.
	task automatic drain;
		start <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	function automatic logic [31:0] pick_live_id(output bit found);
		int idx[$];
		for (int i = 0; i < SLOTS; i++)
			if (slot_live[i])
				idx = {idx, i};
		found = (idx.size() != 0);
		if (!found)
			return '0;
		return slot_id[idx[$urandom_range(0, idx.size() - 1)]];
	endfunction

	function automatic ptt_pkg::req_t make_random_word;
		ptt_pkg::req_t w;
		int unsigned   r;
		bit            found;
		logic [31:0]   live;
		r               = $urandom_range(0, 99);
		w.opcode        = (r < 5) ? OP_NONE : (r < 45) ? ptt_pkg::OP_REGISTER :
			(r < 78) ? ptt_pkg::OP_RELEASE : ptt_pkg::OP_TICK;
		w.request_id    = $urandom;
		w.response_data = $urandom;
		r               = $urandom_range(0, 99);
		w.timeout_ticks = (r < 10) ? 16'd0 : (r < 20) ? 16'($urandom_range(0, 65535)) :
			16'($urandom_range(1, 6));
		live = pick_live_id(found);
		r    = $urandom_range(0, 99);
		if (w.opcode == ptt_pkg::OP_REGISTER) begin
			// mix in duplicates and the id extremes
			if (r < 25 && found)
				w.request_id = live;
			else if (r < 30)
				w.request_id = '0;
			else if (r < 35)
				w.request_id = '1;
		end else if (w.opcode == ptt_pkg::OP_RELEASE) begin
			if (r < 70 && found)
				w.request_id = live;
		end
		return w;
	endfunction

	// compare each result word with the oldest one awaited
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("unexpected result word, id", result.result_id, '0);
			end else begin
				oldest = awaited_results.pop_front();
				if (result.status !== oldest.status)
					flag_mismatch("status", 32'(result.status), 32'(oldest.status));
				if (result.result_id !== oldest.result_id)
					flag_mismatch("result_id", result.result_id, oldest.result_id);
				if (result.result_data !== oldest.result_data)
					flag_mismatch("result_data", result.result_data, oldest.result_data);
				if (result.last !== oldest.last)
					flag_mismatch("last", 32'(result.last), 32'(oldest.last));
			end
		end
	end

	initial begin
		ptt_pkg::req_t w;
		int            done;
		int            guard;
		int unsigned   idle_pct;
		mismatches = 0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i]  = 1'b0;
			slot_id[i]    = '0;
			slot_count[i] = '0;
		end
		arst_n <= 1'b0;
		start  <= 1'b0;
		req    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan: misses, extremes, duplicates, ignored opcode, fill to full,
		// sixteen expiries on one tick, tick on an empty table
		add_row(row(ptt_pkg::OP_RELEASE, 32'h0, 16'h0, 32'hDEAD_BEEF, 1, 1'b1,
			ptt_pkg::ST_NOT_FOUND, 32'h0, 32'h0));
		add_row(row(ptt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 1, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));
		add_row(row(ptt_pkg::OP_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1,
			ptt_pkg::ST_ACCEPTED, 32'hFFFF_FFFF, 32'h0));
		add_row(row(ptt_pkg::OP_REGISTER, 32'h0, 16'h0, 32'h0, 1, 1'b1,
			ptt_pkg::ST_ACCEPTED, 32'h0, 32'h0));
		add_row(row(ptt_pkg::OP_REGISTER, 32'hA5A5_5A5A, 16'd2, 32'h0, 1, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));
		add_row(row(ptt_pkg::OP_REGISTER, 32'hA5A5_5A5A, 16'd3, 32'h0, 1, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));
		add_row(row(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));
		add_row(row(ptt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 1, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));
		add_row(row(ptt_pkg::OP_RELEASE, 32'hA5A5_5A5A, 16'h0, 32'hFFFF_FFFF, 1, 1'b1,
			ptt_pkg::ST_RELEASED, 32'hA5A5_5A5A, 32'hFFFF_FFFF));
		add_row(row(ptt_pkg::OP_RELEASE, 32'hA5A5_5A5A, 16'h0, 32'h0, 1, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));
		add_row(row(ptt_pkg::OP_RELEASE, 32'hA5A5_5A5A, 16'h0, 32'h5, 1, 1'b1,
			ptt_pkg::ST_NOT_FOUND, 32'hA5A5_5A5A, 32'h0));
		add_row(row(ptt_pkg::OP_RELEASE, 32'hFFFF_FFFF, 16'h0, 32'h1234_5678, 1, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));
		add_row(row(ptt_pkg::OP_REGISTER, 32'h100, 16'd1, 32'h0, SLOTS, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));
		add_row(row(ptt_pkg::OP_REGISTER, 32'hFFFF_FFFF, 16'd7, 32'h0, 1, 1'b1,
			ptt_pkg::ST_FULL, 32'hFFFF_FFFF, 32'h0));
		add_row(row(ptt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 1, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));
		add_row(row(ptt_pkg::OP_TICK, 32'h0, 16'h0, 32'h0, 1, 1'b0,
			ptt_pkg::ST_ACCEPTED, '0, '0));

		foreach (plan[i]) begin
			for (int unsigned k = 0; k < plan[i].reps; k++) begin
				w            = plan[i].w;
				w.request_id = w.request_id + k;
				if (plan[i].typed)
					queue_result(plan[i].lit);
				send_word(w, !plan[i].typed);
			end
		end
		drain();

		// random traffic in three phases: two with sender idling, then one with none
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 32 : (ph == 1) ? 85 : 0;
			done     = 0;
			while (done < PHASE_LEN) begin
				// idle the sender with the phase's odds before each word
				while ($urandom_range(0, 99) < idle_pct) begin
					start <= 1'b0;
					@(posedge clk);
				end
				w = make_random_word();
				send_word(w, 1'b1);
				if (w.opcode != OP_NONE)
					done++;
			end
			// hold off the sender until the block has delivered everything
			drain();
		end

		start <= 1'b0;
		guard = 0;
		while (awaited_results.size() != 0 && guard < DRAIN_MAX) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (awaited_results.size() != 0)
			flag_mismatch("result words never seen, count", 32'(awaited_results.size()),
				32'd0);

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
